[sv/iirdf1_pkg.sv]
// Shared types and constants for the direct-form-I IIR filter core.
package iirdf1_pkg;

  localparam int TAPS_DEFAULT = 7;
  localparam int NUM_REGS     = 7;
  localparam int REG_IW       = 3;
  localparam int PADDR_W      = 6;
  localparam int CFG_W        = 64;
  localparam int COEF_W       = 32;
  localparam int SAMPLE_W     = 16;
  localparam int YHIST_W      = 32;
  localparam int ACC_W        = 64;

  localparam logic [CFG_W-1:0] COEF0_RESET = 64'h0800_0000_0000_0000;

  typedef struct packed {
    logic signed [YHIST_W-1:0]  y;
    logic signed [SAMPLE_W-1:0] x;
  } hist_t;

  typedef struct packed {
    logic clr;
    logic mul;
    logic sub;
    logic shl;
  } mac_ctrl_t;

  typedef logic [NUM_REGS-1:0][CFG_W-1:0] coef_bank_t;

endpackage

[sv/iirdf1_regs.sv]
// Coefficient register bank behind the APB-style configuration port.
module iirdf1_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [iirdf1_pkg::PADDR_W-1:0] paddr,
  input  logic [iirdf1_pkg::CFG_W-1:0]  pwdata,
  output logic [iirdf1_pkg::CFG_W-1:0]  prdata,
  output iirdf1_pkg::coef_bank_t        coef
);
  import iirdf1_pkg::*;

  coef_bank_t        coef_r;
  coef_bank_t        coef_nxt;
  logic [REG_IW-1:0] idx;
  logic              idx_ok;

  assign idx    = paddr[PADDR_W-1:3];
  assign idx_ok = idx < REG_IW'(NUM_REGS);

  always_comb begin
    coef_nxt = coef_r;
    if (psel && penable && pwrite && idx_ok) begin
      coef_nxt[idx] = pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r    <= '0;
      coef_r[0] <= COEF0_RESET;
    end else begin
      coef_r <= coef_nxt;
    end
  end

  assign prdata = idx_ok ? coef_r[idx] : '0;
  assign coef   = coef_r;

endmodule

[sv/iirdf1_hist_mem.sv]
// History memory: past input and output pairs, registered read.
module iirdf1_hist_mem #(
  parameter int DEPTH = iirdf1_pkg::TAPS_DEFAULT - 1,
  parameter int AW    = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output iirdf1_pkg::hist_t rd_data,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  iirdf1_pkg::hist_t wr_data
);
  import iirdf1_pkg::*;

  hist_t            mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  hist_t            rd_data_r;

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= valid_r[rd_addr] ? mem[rd_addr] : '0;
    end
  end

  assign rd_data = rd_data_r;

endmodule

[sv/iirdf1_mac.sv]
// Shared 32x32 multiplier with registered product and saturating 64-bit accumulator.
module iirdf1_mac (
  input  logic                               clk,
  input  logic                               rst_n,
  input  iirdf1_pkg::mac_ctrl_t              ctrl,
  input  logic signed [iirdf1_pkg::COEF_W-1:0] coef,
  input  logic signed [iirdf1_pkg::COEF_W-1:0] opnd,
  output logic signed [iirdf1_pkg::ACC_W-1:0]  acc
);
  import iirdf1_pkg::*;

  logic signed [ACC_W-1:0] prod_w;
  logic signed [ACC_W-1:0] prod_nxt;
  logic signed [ACC_W-1:0] prod_r;
  logic                    pv_r;
  logic                    sub_r;
  logic signed [ACC_W:0]   pe;
  logic signed [ACC_W:0]   ae;
  logic signed [ACC_W:0]   sum;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_nxt;

  assign prod_w   = ACC_W'(coef) * ACC_W'(opnd);
  assign prod_nxt = ctrl.shl ? (prod_w <<< 8) : prod_w;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r  <= 1'b0;
      sub_r <= 1'b0;
    end else begin
      pv_r  <= ctrl.mul;
      sub_r <= ctrl.sub;
    end
  end

  assign pe  = {prod_r[ACC_W-1], prod_r};
  assign ae  = {acc_r[ACC_W-1], acc_r};
  assign sum = sub_r ? (ae - pe) : (ae + pe);

  always_comb begin
    acc_nxt = acc_r;
    if (ctrl.clr) begin
      acc_nxt = '0;
    end else if (pv_r) begin
      if (sum[ACC_W] != sum[ACC_W-1]) begin
        acc_nxt = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
        acc_nxt = sum[ACC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

[sv/iir_direct_form_one_filter_core.sv]
// Direct-form-I IIR filter core: sequencer, history memory, shared MAC and output stage.
//
// One signed 16-bit sample enters per in_valid/in_ready beat and one filtered
// sample leaves per out_valid/out_ready beat, with out_clipped set when the
// rounded result was saturated to 16 bits. Coefficients are 64-bit registers
// on the APB-style port at byte address 8*k: b_k in bits 63..32, a_k in 31..0.
// A single 32x32 multiplier walks the 2*TAPS-1 products, one per cycle, from
// the oldest tap to the newest; past input/output pairs sit in a TAPS-1 entry
// memory used as a ring, each pair read once and the oldest slot overwritten
// with the new pair when the sample finishes.
// One sample is in flight at a time; in_ready returns with out_valid, so a
// new sample is not taken until the previous one has finished.
// A finished result waits in the output register; while the receiver stalls,
// the next sample is still accepted and computed, and it holds in its last
// cycle until the output register frees.
// Reset (synchronous, rst_n low) clears the histories, sets b0 to 1.0 and all
// other coefficients to zero, and drops out_valid.
module iir_direct_form_one_filter_core #(
  parameter int TAPS = iirdf1_pkg::TAPS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [iirdf1_pkg::SAMPLE_W-1:0] in_sample_in,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [iirdf1_pkg::SAMPLE_W-1:0] out_filtered_out,
  output logic                                  out_clipped,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [iirdf1_pkg::PADDR_W-1:0]        paddr,
  input  logic [iirdf1_pkg::CFG_W-1:0]          pwdata,
  output logic [iirdf1_pkg::CFG_W-1:0]          prdata,
  output logic                                  pready
);
  import iirdf1_pkg::*;

  localparam int D  = TAPS - 1;
  localparam int AW = (D > 1) ? $clog2(D) : 1;
  localparam int SW = $clog2(2 * D + 1);
  localparam logic [AW-1:0] LAST_A = AW'(D - 1);
  localparam logic [SW-1:0] LAST_S = SW'(2 * D);
  localparam logic [SW-1:0] LAST_RD_S = SW'(2 * D - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_RUN   = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  coef_bank_t                coef;
  logic [2:0]                state_r, state_nxt;
  logic [SW-1:0]             s_r, s_nxt;
  logic [AW-1:0]             ptr_r, ptr_nxt;
  logic [AW-1:0]             addr_r, addr_nxt;
  logic signed [SAMPLE_W-1:0] x_r, x_nxt;
  logic                      ovalid_r, ovalid_nxt;
  logic signed [SAMPLE_W-1:0] ofilt_r, ofilt_nxt;
  logic                      oclip_r, oclip_nxt;

  logic                      rd_en;
  hist_t                     rd_data;
  logic                      wr_en;
  hist_t                     wr_data;
  mac_ctrl_t                 mac_ctrl;
  logic [REG_IW-1:0]         tap;
  logic [CFG_W-1:0]          coef_sel;
  logic signed [COEF_W-1:0]  mul_coef;
  logic signed [COEF_W-1:0]  mul_opnd;
  logic signed [ACC_W-1:0]   acc;
  logic [37:0]               yq_w;
  logic [YHIST_W-1:0]        yq_sat;
  logic [29:0]               r_w;
  logic                      r_clip;
  logic                      finish;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] v);
    return (v == LAST_A) ? '0 : v + 1'b1;
  endfunction

  iirdf1_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .coef    (coef)
  );

  iirdf1_hist_mem #(
    .DEPTH (D),
    .AW    (AW)
  ) u_hist (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (addr_r),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wrap_inc(ptr_r)),
    .wr_data (wr_data)
  );

  // operation s: tap D - s/2; even s multiplies b by x, odd s subtracts a*y
  assign tap      = REG_IW'(D) - REG_IW'(s_r >> 1);
  assign coef_sel = coef[tap];
  assign mul_coef = s_r[0] ? coef_sel[COEF_W-1:0] : coef_sel[CFG_W-1:COEF_W];

  always_comb begin
    if (s_r[0]) begin
      mul_opnd = rd_data.y;
    end else if (s_r == LAST_S) begin
      mul_opnd = {{(COEF_W-SAMPLE_W){x_r[SAMPLE_W-1]}}, x_r};
    end else begin
      mul_opnd = {{(COEF_W-SAMPLE_W){rd_data.x[SAMPLE_W-1]}}, rd_data.x};
    end
  end

  assign mac_ctrl.clr = (state_r == S_LOAD);
  assign mac_ctrl.mul = (state_r == S_RUN);
  assign mac_ctrl.sub = s_r[0];
  assign mac_ctrl.shl = !s_r[0];

  iirdf1_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (mac_ctrl),
    .coef  (mul_coef),
    .opnd  (mul_opnd),
    .acc   (acc)
  );

  // Q24.8 store and integer output, both rounded half up
  assign yq_w   = {acc[ACC_W-1], acc[ACC_W-1:27]} + {37'd0, acc[26]};
  assign yq_sat = (yq_w[37:31] == {7{yq_w[37]}}) ? yq_w[31:0] :
                  (yq_w[37] ? 32'h8000_0000 : 32'h7fff_ffff);
  assign r_w    = {acc[ACC_W-1], acc[ACC_W-1:35]} + {29'd0, acc[34]};
  assign r_clip = (r_w[29:15] != {15{r_w[29]}});

  assign finish    = (state_r == S_DONE) && (!ovalid_r || out_ready);
  assign rd_en     = (state_r == S_LOAD) ||
                     ((state_r == S_RUN) && s_r[0] && (s_r != LAST_RD_S));
  assign wr_en     = finish;
  assign wr_data.y = yq_sat;
  assign wr_data.x = x_r;

  always_comb begin
    state_nxt  = state_r;
    s_nxt      = s_r;
    ptr_nxt    = ptr_r;
    addr_nxt   = addr_r;
    x_nxt      = x_r;
    ovalid_nxt = ovalid_r;
    ofilt_nxt  = ofilt_r;
    oclip_nxt  = oclip_r;
    if (ovalid_r && out_ready) begin
      ovalid_nxt = 1'b0;
    end
    if (rd_en) begin
      addr_nxt = wrap_inc(addr_r);
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          x_nxt     = in_sample_in;
          addr_nxt  = wrap_inc(ptr_r);
          s_nxt     = '0;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        state_nxt = S_RUN;
      end
      S_RUN: begin
        if (s_r == LAST_S) begin
          s_nxt     = '0;
          state_nxt = S_DRAIN;
        end else begin
          s_nxt = s_r + 1'b1;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (finish) begin
          ptr_nxt    = wrap_inc(ptr_r);
          ovalid_nxt = 1'b1;
          oclip_nxt  = r_clip;
          if (!r_clip) begin
            ofilt_nxt = r_w[SAMPLE_W-1:0];
          end else begin
            ofilt_nxt = r_w[29] ? 16'sh8000 : 16'sh7fff;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      s_r      <= '0;
      ptr_r    <= '0;
      addr_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      s_r      <= s_nxt;
      ptr_r    <= ptr_nxt;
      addr_r   <= addr_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r     <= x_nxt;
    ofilt_r <= ofilt_nxt;
    oclip_r <= oclip_nxt;
  end

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = ovalid_r;
  assign out_filtered_out = ofilt_r;
  assign out_clipped      = oclip_r;
  assign pready           = 1'b1;

endmodule

[sv/iirdf1_checker.sv]
// Port-level checks for the IIR filter core, bound to the top level.
module iirdf1_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_valid,
  input logic                                  in_ready,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic signed [iirdf1_pkg::SAMPLE_W-1:0] out_filtered_out,
  input logic                                  out_clipped,
  input logic                                  pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_filtered_out) && $stable(out_clipped))
    else $error("stalled output beat changed");

  a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clipped |->
      (out_filtered_out == 16'sh7fff) || (out_filtered_out == -16'sh8000))
    else $error("clipped beat not at a rail");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat taken while one is in flight");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("reset did not clear the channels");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    pready)
    else $error("pready low");

endmodule

bind iir_direct_form_one_filter_core iirdf1_checker u_iirdf1_checker (.*);
